// ===== design/mlfq_pkg.sv =====
`timescale 1ns / 1ps
package mlfq_pkg;
   typedef enum logic [2:0] {
      OP_TICK = 3'd0, OP_ALLOC = 3'd1, OP_RUNNABLE = 3'd2,
      OP_BLOCK = 3'd3, OP_FREE = 3'd4, OP_PICK = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_UNUSED = 2'd0, ST_USED = 2'd1, ST_RUNNABLE = 2'd2, ST_RUNNING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_SLICE0 = 2'd0, CSR_SLICE1 = 2'd1, CSR_SLICE2 = 2'd2, CSR_BOOST = 2'd3
   } csr_type;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_type;

   localparam logic [1:0] TOP_LEVEL = 2'd2;

   typedef struct packed {
      status_type  status;
      logic [1:0]  level;
      logic [7:0]  ticks;
      logic [63:0] stamp;
   } entry_type;

   // command to the head logic while a scan runs
   typedef struct packed {
      logic        active;
      logic [2:0]  op;
      logic        boost;
      logic [7:0]  slice0;
      logic [7:0]  slice1;
      logic [7:0]  slice2;
      logic        pick_hit;
      logic        alloc_hit;
   } ctl_type;
endpackage

// ===== design/mlfq_process_scheduler_top.sv =====
`timescale 1ns / 1ps
// Three-level feedback queue scheduler over a table of NUM_ENTRIES task
// entries held in a rotating row of cells. A pick rotates the whole row once
// to find the oldest runnable entry at the lowest level (also applying a
// pending boost), then every op rotates the row once more, updating the entry
// that passes the head cell. A new item is accepted only once the previous
// result has been taken. The result is held in an output register until
// taken.
module mlfq_process_scheduler_top #(
   parameter int NUM_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [5:0]  req_entry,
   input  logic        req_entry_valid,
   input  logic        req_advances_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_give_up,
   output logic        rsp_found,
   output logic [5:0]  rsp_chosen,
   output logic [1:0]  rsp_chosen_level,
   output logic [7:0]  rsp_remaining_ticks,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   mlfq_pkg::state_type state_ff, state_in;
   mlfq_pkg::entry_type row [NUM_ENTRIES];
   mlfq_pkg::entry_type head_next;
   mlfq_pkg::ctl_type   ctl;

   logic [7:0]  slice0_ff, slice1_ff, slice2_ff;
   logic [15:0] boost_int_ff, icount_ff;
   logic        boost_pend_ff, boost_now_ff;
   logic [63:0] stamp_ff;
   logic [IW-1:0] pos_ff;        // index of entry at head during this pass
   logic        pass_ff;         // 0 search pass, 1 update pass
   logic [2:0]  op_ff;
   logic [5:0]  ent_ff;
   logic        run_ff;
   logic        have_ff, alloc_done_ff;
   logic [IW-1:0] best_ff;
   logic [1:0]  best_lvl_ff;
   logic [63:0] best_stamp_ff;
   logic        y_ff, fnd_ff;
   logic [5:0]  ch_ff;
   logic [1:0]  lvl_ff;
   logic [7:0]  rem_ff;

   logic take_stamp, yield_hit, is_target, shift, accept, last;
   logic [1:0] lvl_o;
   logic [7:0] rem_o;
   mlfq_pkg::entry_type cur;
   logic [1:0] cur_lvl;

   assign cur       = row[0];
   assign cur_lvl   = cur.level;
   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != mlfq_pkg::S_IDLE;
   assign csr_ready = state_ff == mlfq_pkg::S_IDLE;
   assign shift     = state_ff == mlfq_pkg::S_SCAN;
   assign last      = pos_ff[IW-1:0] == IW'(NUM_ENTRIES - 1);
   assign is_target = {{(IW+1 > 6 ? IW-5 : 1){1'b0}}, ent_ff} ==
                      {{(IW+1 > 6 ? 1 : 7-IW){1'b0}}, pos_ff[IW-1:0]};

   always_comb begin
      ctl.active    = shift && pass_ff;
      ctl.op        = op_ff;
      ctl.boost     = boost_now_ff;
      ctl.slice0    = slice0_ff;
      ctl.slice1    = slice1_ff;
      ctl.slice2    = slice2_ff;
      ctl.pick_hit  = have_ff && best_ff == pos_ff[IW-1:0];
      ctl.alloc_hit = !alloc_done_ff && cur.status == mlfq_pkg::ST_UNUSED;
   end

   mlfq_head u_head (
      .ctl(ctl), .is_target(is_target), .advance_req(run_ff),
      .stamp_now(stamp_ff), .entry_cur(cur), .entry_next(head_next),
      .take_stamp(take_stamp), .yield_hit(yield_hit),
      .lvl_out(lvl_o), .rem_out(rem_o)
   );

   for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_row
      mlfq_pkg::entry_type feed;
      assign feed = (g == NUM_ENTRIES - 1) ? (pass_ff ? head_next : row[0])
                                           : row[(g + 1) % NUM_ENTRIES];
      mlfq_cell u_cell (.clock(clock), .reset(reset), .shift(shift),
                        .prev_entry(feed), .entry_out(row[g]));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlfq_pkg::S_IDLE: if (accept) state_in = mlfq_pkg::S_SCAN;
         mlfq_pkg::S_SCAN: if (last && pass_ff) state_in = mlfq_pkg::S_RESP;
         mlfq_pkg::S_RESP: if (!rsp_stall) state_in = mlfq_pkg::S_IDLE;
         default: state_in = mlfq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mlfq_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice0_ff <= 8'd3; slice1_ff <= 8'd6; slice2_ff <= 8'd12;
         boost_int_ff <= 16'd100; icount_ff <= '0; boost_pend_ff <= 1'b0;
         boost_now_ff <= 1'b0; stamp_ff <= '0; pos_ff <= '0; pass_ff <= 1'b0;
         have_ff <= 1'b0; alloc_done_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (mlfq_pkg::csr_type'(csr_index))
               mlfq_pkg::CSR_SLICE0: slice0_ff <= csr_data[7:0];
               mlfq_pkg::CSR_SLICE1: slice1_ff <= csr_data[7:0];
               mlfq_pkg::CSR_SLICE2: slice2_ff <= csr_data[7:0];
               mlfq_pkg::CSR_BOOST:  boost_int_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            logic        run;
            logic [16:0] c;
            logic        y;
            run = req_entry_valid && (int'(req_entry) < NUM_ENTRIES);
            y   = 1'b0;
            op_ff <= req_op; ent_ff <= req_entry; run_ff <= run;
            pos_ff <= '0; have_ff <= 1'b0; alloc_done_ff <= 1'b0;
            boost_now_ff <= 1'b0;
            pass_ff <= req_op != mlfq_pkg::OP_PICK;
            fnd_ff <= 1'b0; ch_ff <= '0; lvl_ff <= '0; rem_ff <= '0;
            c = {1'b0, icount_ff} + 17'd1;
            if (req_op == mlfq_pkg::OP_TICK) begin
               if (req_advances_time) begin
                  if (c >= {1'b0, boost_int_ff}) begin
                     icount_ff <= '0; boost_pend_ff <= 1'b1; y = run;
                  end else icount_ff <= c[15:0];
               end
               if (run && boost_pend_ff) y = 1'b1;
            end
            if (req_op == mlfq_pkg::OP_PICK && boost_pend_ff) begin
               boost_pend_ff <= 1'b0; boost_now_ff <= 1'b1;
            end
            y_ff <= y;
         end else if (shift) begin
            pos_ff <= last ? '0 : pos_ff + 1'b1;
            if (take_stamp) stamp_ff <= stamp_ff + 64'd1;
            if (!pass_ff) begin
               // search: boost would make every runnable level 0, in index order
               if (cur.status == mlfq_pkg::ST_RUNNABLE) begin
                  logic [1:0]  l;
                  logic [63:0] s;
                  l = boost_now_ff ? 2'd0 : cur_lvl;
                  s = boost_now_ff ? 64'd0 : cur.stamp;
                  if (!have_ff || l < best_lvl_ff || (l == best_lvl_ff && s < best_stamp_ff)) begin
                     have_ff <= 1'b1; best_ff <= pos_ff[IW-1:0];
                     best_lvl_ff <= l; best_stamp_ff <= s;
                  end
               end
               if (last) pass_ff <= 1'b1;
            end else begin
               if (ctl.alloc_hit && op_ff == mlfq_pkg::OP_ALLOC) begin
                  alloc_done_ff <= 1'b1; fnd_ff <= 1'b1;
                  ch_ff <= 6'(pos_ff[IW-1:0]);
               end
               if (ctl.pick_hit && op_ff == mlfq_pkg::OP_PICK) begin
                  fnd_ff <= 1'b1; ch_ff <= 6'(pos_ff[IW-1:0]); lvl_ff <= best_lvl_ff;
               end
               if (op_ff == mlfq_pkg::OP_TICK && is_target && run_ff) begin
                  lvl_ff <= lvl_o; rem_ff <= rem_o;
                  if (yield_hit) y_ff <= 1'b1;
               end
               if (last) pass_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_valid           = state_ff == mlfq_pkg::S_RESP;
   assign rsp_give_up         = y_ff;
   assign rsp_found           = fnd_ff;
   assign rsp_chosen          = ch_ff;
   assign rsp_chosen_level    = lvl_ff;
   assign rsp_remaining_ticks = rem_ff;
endmodule

// ===== design/mlfq_cell.sv =====
`timescale 1ns / 1ps
// one table entry; the head cell's entry is acted on, then the row rotates
module mlfq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  mlfq_pkg::entry_type  prev_entry,
   output mlfq_pkg::entry_type  entry_out
);
   mlfq_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= prev_entry;
      end
   end

   assign entry_out = entry_ff;
endmodule

// ===== design/mlfq_head.sv =====
`timescale 1ns / 1ps
// acts on the entry leaving the row head before it re-enters the tail
module mlfq_head (
   input  mlfq_pkg::ctl_type    ctl,
   input  logic                 is_target,
   input  logic                 advance_req,
   input  logic [63:0]          stamp_now,
   input  mlfq_pkg::entry_type  entry_cur,
   output mlfq_pkg::entry_type  entry_next,
   output logic                 take_stamp,
   output logic                 yield_hit,
   output logic [1:0]           lvl_out,
   output logic [7:0]           rem_out
);
   logic [7:0] slice;
   logic [8:0] t;

   always_comb begin
      entry_next = entry_cur;
      take_stamp = 1'b0;
      yield_hit  = 1'b0;
      lvl_out    = '0;
      rem_out    = '0;
      unique case (entry_cur.level)
         2'd0:    slice = ctl.slice0;
         2'd1:    slice = ctl.slice1;
         default: slice = ctl.slice2;
      endcase
      t = {1'b0, entry_cur.ticks} + ((entry_cur.ticks == 8'hff) ? 9'd0 : 9'd1);
      if (ctl.active) begin
         if (ctl.boost && entry_cur.status != mlfq_pkg::ST_UNUSED) begin
            entry_next.level = '0;
            entry_next.ticks = '0;
            if (entry_cur.status == mlfq_pkg::ST_RUNNABLE) begin
               entry_next.stamp = stamp_now;
               take_stamp = 1'b1;
            end
         end
         case (ctl.op)
            mlfq_pkg::OP_TICK: begin
               if (is_target && advance_req
                   && entry_cur.status == mlfq_pkg::ST_RUNNING) begin
                  entry_next.ticks = t[7:0];
                  lvl_out = (entry_cur.level > mlfq_pkg::TOP_LEVEL) ?
                            mlfq_pkg::TOP_LEVEL : entry_cur.level;
                  rem_out = ({1'b0, slice} > t) ? 8'({1'b0, slice} - t) : 8'd0;
                  if (t >= {1'b0, slice}) begin
                     entry_next.level = (entry_cur.level < mlfq_pkg::TOP_LEVEL) ?
                                        entry_cur.level + 2'd1 : mlfq_pkg::TOP_LEVEL;
                     entry_next.ticks = '0;
                     entry_next.stamp = stamp_now;
                     take_stamp = 1'b1;
                     yield_hit  = 1'b1;
                  end
               end
            end
            mlfq_pkg::OP_ALLOC: begin
               if (ctl.alloc_hit) begin
                  entry_next.status = mlfq_pkg::ST_USED;
                  entry_next.level  = '0;
                  entry_next.ticks  = '0;
                  entry_next.stamp  = stamp_now;
                  take_stamp = 1'b1;
               end
            end
            mlfq_pkg::OP_RUNNABLE: begin
               if (is_target && entry_cur.status != mlfq_pkg::ST_UNUSED) begin
                  entry_next.status = mlfq_pkg::ST_RUNNABLE;
                  entry_next.ticks  = '0;
                  entry_next.stamp  = stamp_now;
                  take_stamp = 1'b1;
               end
            end
            mlfq_pkg::OP_BLOCK: begin
               if (is_target && entry_cur.status != mlfq_pkg::ST_UNUSED)
                  entry_next.status = mlfq_pkg::ST_USED;
            end
            mlfq_pkg::OP_FREE: begin
               if (is_target) entry_next = '0;
            end
            mlfq_pkg::OP_PICK: begin
               if (ctl.pick_hit) entry_next.status = mlfq_pkg::ST_RUNNING;
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== design/mlfq_checker.sv =====
`timescale 1ns / 1ps
module mlfq_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_found,
   input logic [5:0] rsp_chosen,
   input logic [1:0] rsp_chosen_level,
   input logic       csr_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chosen))
      else $error("stalled result changed");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !rsp_valid)
      else $error("config open while busy");
   a_notfound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_chosen == 6'd0)
      else $error("chosen set without found");
   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chosen_level != 2'd3)
      else $error("bad level");
endmodule

bind mlfq_process_scheduler_top mlfq_checker u_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
   .rsp_chosen(rsp_chosen), .rsp_chosen_level(rsp_chosen_level),
   .csr_ready(csr_ready)
);

// ===== tb/mlfq_process_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
module mlfq_process_scheduler_top_tb;
   localparam int          TABLE_SIZE   = 64;
   localparam int          DRAIN_CYCLES = 150;
   localparam int          IDLE_LIMIT   = 4000;
   localparam logic [2:0]  OP_SPARE_A   = 3'd6;
   localparam logic [2:0]  OP_SPARE_B   = 3'd7;

   typedef struct {
      logic       give_up;
      logic       found;
      logic [5:0] chosen;
      logic [1:0] level;
      logic [7:0] remaining;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [5:0]  req_entry = '0;
   logic        req_entry_valid = 1'b0;
   logic        req_advances_time = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_give_up;
   logic        rsp_found;
   logic [5:0]  rsp_chosen;
   logic [1:0]  rsp_chosen_level;
   logic [7:0]  rsp_remaining_ticks;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   mlfq_process_scheduler_top uut (.*);

   // predictor copy of the scheduler
   mlfq_pkg::status_type tbl_status [TABLE_SIZE];
   logic [1:0]  tbl_level  [TABLE_SIZE];
   logic [7:0]  tbl_ticks  [TABLE_SIZE];
   logic [63:0] tbl_stamp  [TABLE_SIZE];
   logic [63:0] next_stamp;
   logic [15:0] boost_count;
   logic        boost_waiting;
   logic [7:0]  slice_q [3];
   logic [15:0] boost_period;
   logic [5:0]  last_running;

   sched_result_type pending_results[$];
   int errors = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_hold = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] take_stamp();
      logic [63:0] s;
      s = next_stamp;
      next_stamp = next_stamp + 64'd1;
      return s;
   endfunction

   task automatic predict_event(input logic [2:0] op, input logic [5:0] e, input logic v,
                                input logic adv, output sched_result_type r);
      logic [16:0] c;
      int          lv;
      int          sl;
      int          t;
      int          best;
      logic [1:0]  best_lv;
      logic [63:0] best_st;
      r = '{default: '0};
      case (op)
         mlfq_pkg::OP_TICK: begin
            if (adv) begin
               c = {1'b0, boost_count} + 17'd1;
               if (c >= {1'b0, boost_period}) begin
                  c = '0;
                  boost_waiting = 1'b1;
                  if (v) r.give_up = 1'b1;
               end
               boost_count = c[15:0];
            end
            if (v) begin
               if (boost_waiting) r.give_up = 1'b1;
               if (tbl_status[e] == mlfq_pkg::ST_RUNNING) begin
                  lv = tbl_level[e];
                  sl = (lv == 0) ? slice_q[0] : (lv == 1) ? slice_q[1] : slice_q[2];
                  t = tbl_ticks[e];
                  if (t < 255) t++;
                  tbl_ticks[e] = t[7:0];
                  r.level = (lv > 2) ? 2'd2 : lv[1:0];
                  r.remaining = (t < sl) ? 8'(sl - t) : 8'd0;
                  if (t >= sl) begin
                     tbl_level[e] = (lv < 2) ? 2'(lv + 1) : mlfq_pkg::TOP_LEVEL;
                     tbl_ticks[e] = '0;
                     tbl_stamp[e] = take_stamp();
                     r.give_up = 1'b1;
                  end
               end
            end
         end
         mlfq_pkg::OP_ALLOC: begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (tbl_status[i] == mlfq_pkg::ST_UNUSED && !r.found) begin
                  tbl_status[i] = mlfq_pkg::ST_USED;
                  tbl_level[i] = '0;
                  tbl_ticks[i] = '0;
                  tbl_stamp[i] = take_stamp();
                  r.found = 1'b1;
                  r.chosen = i[5:0];
               end
            end
         end
         mlfq_pkg::OP_RUNNABLE: begin
            if (tbl_status[e] != mlfq_pkg::ST_UNUSED) begin
               tbl_status[e] = mlfq_pkg::ST_RUNNABLE;
               tbl_ticks[e] = '0;
               tbl_stamp[e] = take_stamp();
            end
         end
         mlfq_pkg::OP_BLOCK: begin
            if (tbl_status[e] != mlfq_pkg::ST_UNUSED) tbl_status[e] = mlfq_pkg::ST_USED;
         end
         mlfq_pkg::OP_FREE: begin
            tbl_status[e] = mlfq_pkg::ST_UNUSED;
            tbl_level[e] = '0;
            tbl_ticks[e] = '0;
            tbl_stamp[e] = '0;
         end
         mlfq_pkg::OP_PICK: begin
            if (boost_waiting) begin
               boost_waiting = 1'b0;
               for (int i = 0; i < TABLE_SIZE; i++) begin
                  if (tbl_status[i] != mlfq_pkg::ST_UNUSED) begin
                     tbl_level[i] = '0;
                     tbl_ticks[i] = '0;
                     if (tbl_status[i] == mlfq_pkg::ST_RUNNABLE) tbl_stamp[i] = take_stamp();
                  end
               end
            end
            best = -1;
            best_lv = '0;
            best_st = '0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (tbl_status[i] == mlfq_pkg::ST_RUNNABLE) begin
                  if (best < 0 || tbl_level[i] < best_lv ||
                      (tbl_level[i] == best_lv && tbl_stamp[i] < best_st)) begin
                     best = i;
                     best_lv = tbl_level[i];
                     best_st = tbl_stamp[i];
                  end
               end
            end
            if (best >= 0) begin
               tbl_status[best] = mlfq_pkg::ST_RUNNING;
               r.found = 1'b1;
               r.chosen = best[5:0];
               r.level = best_lv;
               last_running = best[5:0];
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [2:0] op, input logic [5:0] e,
                            input logic v = 1'b1, input logic adv = 1'b1);
      sched_result_type r;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_entry <= e;
      req_entry_valid <= v;
      req_advances_time <= adv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_event(op, e, v, adv, r);
      pending_results.push_back(r);
   endtask

   // hold off new items until the block has drained
   task automatic drain_all();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] s0, input logic [15:0] s1,
                             input logic [15:0] s2, input logic [15:0] bi);
      logic [15:0] vals [4];
      vals = '{s0, s1, s2, bi};
      drain_all();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[1:0];
         csr_data <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (mlfq_pkg::csr_type'(i[1:0]))
            mlfq_pkg::CSR_SLICE0: slice_q[0] = vals[i][7:0];
            mlfq_pkg::CSR_SLICE1: slice_q[1] = vals[i][7:0];
            mlfq_pkg::CSR_SLICE2: slice_q[2] = vals[i][7:0];
            mlfq_pkg::CSR_BOOST:  boost_period = vals[i];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      sched_result_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            w = pending_results.pop_front();
            if (rsp_give_up !== w.give_up) report_mismatch("give_up", rsp_give_up, w.give_up);
            if (rsp_found !== w.found) report_mismatch("found", rsp_found, w.found);
            if (rsp_chosen !== w.chosen) report_mismatch("chosen", rsp_chosen, w.chosen);
            if (rsp_chosen_level !== w.level)
               report_mismatch("chosen_level", rsp_chosen_level, w.level);
            if (rsp_remaining_ticks !== w.remaining)
               report_mismatch("remaining_ticks", rsp_remaining_ticks, w.remaining);
         end
      end
   end

   // receiver stall pattern: free-running, light and heavy stretches
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_hold = $urandom_range(50, 400);
      end else begin
         stall_hold--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("mlfq_process_scheduler_top regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_empty_table();
      send_item(mlfq_pkg::OP_PICK, 6'd0);
      send_item(mlfq_pkg::OP_TICK, 6'd0, 1'b0, 1'b0);
      send_item(mlfq_pkg::OP_TICK, 6'd5, 1'b1, 1'b0);
      send_item(OP_SPARE_A, 6'd63, 1'b1, 1'b1);
      send_item(OP_SPARE_B, 6'd42, 1'b0, 1'b1);
      send_item(mlfq_pkg::OP_RUNNABLE, 6'd63);
      send_item(mlfq_pkg::OP_BLOCK, 6'd63);
      send_item(mlfq_pkg::OP_FREE, 6'd63);
   endtask

   task automatic test_alloc_pick();
      repeat (4) send_item(mlfq_pkg::OP_ALLOC, 6'd0);
      send_item(mlfq_pkg::OP_RUNNABLE, 6'd2);
      send_item(mlfq_pkg::OP_RUNNABLE, 6'd0);
      send_item(mlfq_pkg::OP_PICK, 6'd0);
      send_item(mlfq_pkg::OP_PICK, 6'd0);
      send_item(mlfq_pkg::OP_PICK, 6'd0);
      send_item(mlfq_pkg::OP_BLOCK, 6'd0);
      send_item(mlfq_pkg::OP_BLOCK, 6'd3);
   endtask

   // zero slice on level 0, then level 2 stays put on expiry
   task automatic test_slice_demotion();
      set_config(16'hff00, 16'd2, 16'd1, 16'hffff);
      for (int i = 0; i < 5; i++) send_item(mlfq_pkg::OP_TICK, 6'd2, 1'b1, 1'b0);
      send_item(mlfq_pkg::OP_TICK, 6'd1, 1'b1, 1'b1);
   endtask

   task automatic test_boost();
      set_config(16'd3, 16'd4, 16'd5, 16'd2);
      send_item(mlfq_pkg::OP_RUNNABLE, 6'd1);
      send_item(mlfq_pkg::OP_TICK, 6'd2, 1'b1, 1'b1);
      send_item(mlfq_pkg::OP_TICK, 6'd2, 1'b1, 1'b1);
      send_item(mlfq_pkg::OP_TICK, 6'd2, 1'b1, 1'b0);
      send_item(mlfq_pkg::OP_PICK, 6'd0);
      send_item(mlfq_pkg::OP_FREE, 6'd2);
   endtask

   task automatic test_table_full();
      repeat (TABLE_SIZE + 1) send_item(mlfq_pkg::OP_ALLOC, 6'd0);
      send_item(mlfq_pkg::OP_FREE, 6'd17);
      send_item(mlfq_pkg::OP_ALLOC, 6'd0);
   endtask

   task automatic test_random_phase(input int count, input bit alloc_heavy);
      int          r;
      logic [2:0]  op;
      logic [5:0]  e;
      logic        v;
      logic        adv;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (alloc_heavy && r < 50) op = mlfq_pkg::OP_ALLOC;
         else if (r < 40) op = mlfq_pkg::OP_TICK;
         else if (r < 48) op = mlfq_pkg::OP_ALLOC;
         else if (r < 65) op = mlfq_pkg::OP_RUNNABLE;
         else if (r < 72) op = mlfq_pkg::OP_BLOCK;
         else if (r < 80) op = mlfq_pkg::OP_FREE;
         else if (r < 95) op = mlfq_pkg::OP_PICK;
         else op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
         if (op == mlfq_pkg::OP_TICK) begin
            e = ($urandom_range(0, 99) < 85) ? last_running : 6'($urandom_range(0, 63));
            v = ($urandom_range(0, 9) != 0);
            adv = ($urandom_range(0, 3) != 0);
         end else begin
            e = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 11))
                                           : 6'($urandom_range(0, 63));
            v = 1'($urandom_range(0, 1));
            adv = 1'($urandom_range(0, 1));
         end
         send_item(op, e, v, adv);
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         tbl_status[i] = mlfq_pkg::ST_UNUSED;
         tbl_level[i] = '0;
         tbl_ticks[i] = '0;
         tbl_stamp[i] = '0;
      end
      next_stamp = '0;
      boost_count = '0;
      boost_waiting = 1'b0;
      slice_q = '{8'd3, 8'd6, 8'd12};
      boost_period = 16'd100;
      last_running = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_alloc_pick();
      test_slice_demotion();
      test_boost();
      test_table_full();
      set_config(16'd3, 16'd6, 16'd12, 16'd100);
      test_random_phase(100, 1'b0);
      set_config(16'd255, 16'd255, 16'd255, 16'd65535);
      test_random_phase(150, 1'b0);
      set_config(16'd0, 16'd0, 16'd0, 16'd0);
      test_random_phase(150, 1'b0);
      set_config(16'd1, 16'd2, 16'd3, 16'd7);
      test_random_phase(150, 1'b1);
      set_config(16'd1, 16'd1, 16'd1, 16'd1);
      test_random_phase(150, 1'b0);
      set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(1, 40)));
      test_random_phase(150, 1'b0);
      set_config(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 8)), 16'($urandom_range(5, 30)));
      test_random_phase(150, 1'b0);

      drain_all();
      if (errors == 0) begin
         $display("mlfq_process_scheduler_top regression: pass");
      end else begin
         $display("mlfq_process_scheduler_top regression: fail");
      end
      $finish;
   end
endmodule

// ===== files.f =====
design/mlfq_pkg.sv
design/mlfq_cell.sv
design/mlfq_head.sv
design/mlfq_process_scheduler_top.sv
design/mlfq_checker.sv
tb/mlfq_process_scheduler_top_tb.sv
